// ===== hdl/rc5_pkg.sv =====
package rc5_pkg;

    localparam logic [31:0] MAGIC_P    = 32'hB7E15163;
    localparam logic [31:0] MAGIC_Q    = 32'h9E3779B9;
    localparam int          KEY_WORDS  = 4;
    localparam int          MIX_PASSES = 3;
    localparam int          FIFO_DEPTH = 2;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam int        CFG_IDX_W    = 1;
    localparam logic      REG_KEY_LOW  = 1'b0;
    localparam logic      REG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic        last;
    } item_t;

    typedef struct packed {
        logic                 write;
        logic [CFG_IDX_W-1:0] index;
        logic [63:0]          data;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] w;
        w = {v, v} << n;
        return w[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] w;
        w = {v, v} >> n;
        return w[31:0];
    endfunction

endpackage

// ===== hdl/rc5_block_cipher.sv =====
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------------------
// input    | start, busy (accept when   | command, word_a_in, word_b_in, last_in
//          | start && !busy)            |
// result   | done (one-cycle strobe)    | word_a_out, word_b_out, last_out
// config   | cfg_write                  | cfg_index, cfg_data
//
// A beat passes an input register and a two-entry queue, then the round engine.
// The engine does one full round per cycle.
// After reset or a key write the next block first waits for key expansion: the key words
// and counters are set up, then 3 * (2 * ROUNDS + 2) mixing steps run, one per cycle.
// busy rises only when the queue and the input register are both full.
// The receiver cannot stall: done is high for exactly one cycle per result.
module rc5_block_cipher #(
    parameter int ROUNDS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          command,
    input  logic [31:0]                   word_a_in,
    input  logic [31:0]                   word_b_in,
    input  logic                          last_in,
    output logic                          done,
    output logic [31:0]                   word_a_out,
    output logic [31:0]                   word_b_out,
    output logic                          last_out,
    input  logic                          cfg_write,
    input  logic [rc5_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);
    import rc5_pkg::*;

    cfg_t         cfg;
    fifo_status_t fifo_status;
    item_t        push_item;
    item_t        head_item;
    logic         push;
    logic         pop;

    assign cfg.write = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    rc5_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .word_a_in   (word_a_in),
        .word_b_in   (word_b_in),
        .last_in     (last_in),
        .busy        (busy),
        .fifo_status (fifo_status),
        .push        (push),
        .push_item   (push_item)
    );

    rc5_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (fifo_status)
    );

    rc5_back #(
        .ROUNDS (ROUNDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head_item   (head_item),
        .fifo_status (fifo_status),
        .pop         (pop),
        .done        (done),
        .word_a_out  (word_a_out),
        .word_b_out  (word_b_out),
        .last_out    (last_out)
    );

endmodule

// ===== hdl/rc5_front.sv =====
module rc5_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  command,
    input  logic [31:0]           word_a_in,
    input  logic [31:0]           word_b_in,
    input  logic                  last_in,
    output logic                  busy,
    input  rc5_pkg::fifo_status_t fifo_status,
    output logic                  push,
    output rc5_pkg::item_t        push_item
);
    import rc5_pkg::*;

    item_t item_reg;
    item_t item_next;
    logic  valid_reg;
    logic  valid_next;
    logic  accept;

    assign push      = valid_reg && !fifo_status.full;
    assign busy      = valid_reg && fifo_status.full;
    assign accept    = start && !busy;
    assign push_item = item_reg;

    always_comb
    begin
        item_next  = item_reg;
        valid_next = valid_reg;
        if (accept)
        begin
            item_next.command = command;
            item_next.word_a  = word_a_in;
            item_next.word_b  = word_b_in;
            item_next.last    = last_in;
            valid_next        = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== hdl/rc5_fifo.sv =====
module rc5_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rc5_pkg::item_t        push_item,
    input  logic                  pop,
    output rc5_pkg::item_t        head_item,
    output rc5_pkg::fifo_status_t status
);
    import rc5_pkg::*;

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    item_t           entry_reg [FIFO_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign status.full  = (count_reg == CW'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_item    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && status.empty))
        else $error("queue pop while empty");

endmodule

// ===== hdl/rc5_back.sv =====
module rc5_back #(
    parameter int ROUNDS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rc5_pkg::cfg_t         cfg,
    input  rc5_pkg::item_t        head_item,
    input  rc5_pkg::fifo_status_t fifo_status,
    output logic                  pop,
    output logic                  done,
    output logic [31:0]           word_a_out,
    output logic [31:0]           word_b_out,
    output logic                  last_out
);
    import rc5_pkg::*;

    localparam int TBL   = 2 * ROUNDS + 2;
    localparam int AW    = $clog2(TBL);
    localparam int JW    = $clog2(ROUNDS + 1);
    localparam int STEPS = MIX_PASSES * TBL;
    localparam int SW    = $clog2(STEPS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXPAND = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [63:0]   key_low_reg;
    logic [63:0]   key_low_next;
    logic [63:0]   key_high_reg;
    logic [63:0]   key_high_next;
    logic          ready_reg;
    logic          ready_next;

    // key schedule
    logic [31:0]   scratch_reg [KEY_WORDS];
    logic [31:0]   scratch_next [KEY_WORDS];
    logic [SW-1:0] step_reg;
    logic [SW-1:0] step_next;
    logic [AW-1:0] si_reg;
    logic [AW-1:0] si_next;
    logic [1:0]    ki_reg;
    logic [1:0]    ki_next;
    logic [31:0]   xa_reg;
    logic [31:0]   xa_next;
    logic [31:0]   xb_reg;
    logic [31:0]   xb_next;
    logic [31:0]   init_reg;
    logic [31:0]   init_next;
    logic [31:0]   s_val;
    logic [31:0]   mix_a;
    logic [31:0]   mix_ab;
    logic [31:0]   mix_b;

    // cipher
    logic [JW-1:0] j_reg;
    logic [JW-1:0] j_next;
    logic [JW-1:0] j_step;
    logic [JW-1:0] j_first;
    logic          cmd_reg;
    logic          cmd_next;
    logic          last_reg;
    logic          last_next;
    logic [31:0]   wa_reg;
    logic [31:0]   wa_next;
    logic [31:0]   wb_reg;
    logic [31:0]   wb_next;
    logic [31:0]   ra;
    logic [31:0]   rb;
    logic [31:0]   enc_t;
    logic [31:0]   dec_t;
    logic          final_step;

    // subkey memory
    logic [31:0]   table_mem [TBL];
    logic [31:0]   rd_a_reg;
    logic [31:0]   rd_b_reg;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic          mem_we;

    logic          done_reg;
    logic          done_next;
    logic [31:0]   out_a_reg;
    logic [31:0]   out_b_reg;
    logic          out_last_reg;

    assign done       = done_reg;
    assign word_a_out = out_a_reg;
    assign word_b_out = out_b_reg;
    assign last_out   = out_last_reg;

    assign s_val  = (step_reg < SW'(TBL)) ? init_reg : rd_a_reg;
    assign mix_a  = rotl32(s_val + xa_reg + xb_reg, 5'd3);
    assign mix_ab = mix_a + xb_reg;
    assign mix_b  = rotl32(scratch_reg[ki_reg] + mix_ab, mix_ab[4:0]);

    assign final_step = (cmd_reg == CMD_ENCRYPT) ? (j_reg == JW'(ROUNDS)) : (j_reg == '0);
    assign j_step     = (cmd_reg == CMD_ENCRYPT) ? j_reg + 1'b1 : j_reg - 1'b1;
    assign j_first    = (head_item.command == CMD_ENCRYPT) ? '0 : JW'(ROUNDS);

    assign enc_t = rotl32(wa_reg ^ wb_reg, wb_reg[4:0]) + rd_a_reg;
    assign dec_t = rotr32(wb_reg - rd_b_reg, wa_reg[4:0]) ^ wa_reg;

    always_comb
    begin
        if (cmd_reg == CMD_ENCRYPT)
        begin
            if (j_reg == '0)
            begin
                ra = wa_reg + rd_a_reg;
                rb = wb_reg + rd_b_reg;
            end
            else
            begin
                ra = enc_t;
                rb = rotl32(wb_reg ^ enc_t, enc_t[4:0]) + rd_b_reg;
            end
        end
        else
        begin
            if (j_reg == '0)
            begin
                ra = wa_reg - rd_a_reg;
                rb = wb_reg - rd_b_reg;
            end
            else
            begin
                ra = rotr32(wa_reg - rd_a_reg, dec_t[4:0]) ^ dec_t;
                rb = dec_t;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        ready_next    = ready_reg;
        scratch_next  = scratch_reg;
        step_next     = step_reg;
        si_next       = si_reg;
        ki_next       = ki_reg;
        xa_next       = xa_reg;
        xb_next       = xb_reg;
        init_next     = init_reg;
        j_next        = j_reg;
        cmd_next      = cmd_reg;
        last_next     = last_reg;
        wa_next       = wa_reg;
        wb_next       = wb_reg;
        done_next     = 1'b0;
        pop           = 1'b0;
        mem_we        = 1'b0;
        addr_a        = AW'({j_first, 1'b0});
        addr_b        = AW'({j_first, 1'b1});

        if (cfg.write)
        begin
            case (cfg.index)
                REG_KEY_LOW:
                begin
                    key_low_next = cfg.data;
                    ready_next   = 1'b0;
                end
                REG_KEY_HIGH:
                begin
                    key_high_next = cfg.data;
                    ready_next    = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_status.empty)
                begin
                    if (!ready_reg)
                    begin
                        scratch_next[0] = key_low_reg[31:0];
                        scratch_next[1] = key_low_reg[63:32];
                        scratch_next[2] = key_high_reg[31:0];
                        scratch_next[3] = key_high_reg[63:32];
                        step_next       = '0;
                        si_next         = '0;
                        ki_next         = '0;
                        xa_next         = '0;
                        xb_next         = '0;
                        init_next       = MAGIC_P;
                        state_next      = ST_EXPAND;
                    end
                    else
                    begin
                        pop        = 1'b1;
                        cmd_next   = head_item.command;
                        last_next  = head_item.last;
                        wa_next    = head_item.word_a;
                        wb_next    = head_item.word_b;
                        j_next     = j_first;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_EXPAND:
            begin
                mem_we                = 1'b1;
                scratch_next[ki_reg]  = mix_b;
                xa_next               = mix_a;
                xb_next               = mix_b;
                si_next               = (si_reg == AW'(TBL - 1)) ? '0 : si_reg + 1'b1;
                ki_next               = ki_reg + 1'b1;
                init_next             = init_reg + MAGIC_Q;
                step_next             = step_reg + 1'b1;
                addr_a                = si_next;
                if (step_reg == SW'(STEPS - 1))
                begin
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                wa_next = ra;
                wb_next = rb;
                j_next  = j_step;
                addr_a  = AW'({j_step, 1'b0});
                addr_b  = AW'({j_step, 1'b1});
                if (final_step)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            key_low_reg  <= '0;
            key_high_reg <= '0;
            ready_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
            ready_reg    <= ready_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scratch_reg <= scratch_next;
        step_reg    <= step_next;
        si_reg      <= si_next;
        ki_reg      <= ki_next;
        xa_reg      <= xa_next;
        xb_reg      <= xb_next;
        init_reg    <= init_next;
        j_reg       <= j_next;
        cmd_reg     <= cmd_next;
        last_reg    <= last_next;
        wa_reg      <= wa_next;
        wb_reg      <= wb_next;
        if (done_next)
        begin
            out_a_reg    <= ra;
            out_b_reg    <= rb;
            out_last_reg <= last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[si_reg] <= mix_a;
        end
        rd_a_reg <= table_mem[addr_a];
        rd_b_reg <= table_mem[addr_b];
    end

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == ST_RUN)
        else $error("result beat without a final round");

    a_pop_needs_schedule: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> ready_reg && state_reg == ST_IDLE)
        else $error("block taken before key schedule is ready");

    a_table_write_in_expand: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == ST_EXPAND)
        else $error("subkey table written outside expansion");

    a_run_has_schedule: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> ready_reg)
        else $error("rounds running on a stale schedule");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rc5_pkg::*;

    localparam int ROUNDS_N        = 12;
    localparam int SUBKEYS         = 2 * ROUNDS_N + 2;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_PRINTED     = 50;

    typedef struct {
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic        last;
    } block_out_t;

    class cipher_scoreboard;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [31:0] subkeys[SUBKEYS];
        bit          schedule_valid;
        block_out_t  expected_blocks[$];
        int          mismatches;

        function new();
            key_lo         = '0;
            key_hi         = '0;
            schedule_valid = 1'b0;
            mismatches     = 0;
        endfunction

        function logic [31:0] rol(logic [31:0] v, logic [4:0] n);
            if (n == 5'd0)
                return v;
            return (v << n) | (v >> (6'd32 - n));
        endfunction

        function logic [31:0] ror(logic [31:0] v, logic [4:0] n);
            if (n == 5'd0)
                return v;
            return (v >> n) | (v << (6'd32 - n));
        endfunction

        function void expand_schedule();
            logic [31:0] kw[KEY_WORDS];
            logic [31:0] x;
            logic [31:0] y;
            logic [31:0] amt;
            int          si;
            int          ki;
            int          steps;
            kw[0] = key_lo[31:0];
            kw[1] = key_lo[63:32];
            kw[2] = key_hi[31:0];
            kw[3] = key_hi[63:32];
            subkeys[0] = MAGIC_P;
            for (int i = 1; i < SUBKEYS; i++)
                subkeys[i] = subkeys[i-1] + MAGIC_Q;
            x     = '0;
            y     = '0;
            si    = 0;
            ki    = 0;
            steps = MIX_PASSES * ((SUBKEYS > KEY_WORDS) ? SUBKEYS : KEY_WORDS);
            for (int s = 0; s < steps; s++)
            begin
                x           = rol(subkeys[si] + x + y, 5'd3);
                subkeys[si] = x;
                si          = (si + 1) % SUBKEYS;
                amt         = x + y;
                y           = rol(kw[ki] + x + y, amt[4:0]);
                kw[ki]      = y;
                ki          = (ki + 1) % KEY_WORDS;
            end
            schedule_valid = 1'b1;
        endfunction

        function block_out_t rc5_transform(logic cmd, logic [31:0] a_in, logic [31:0] b_in,
                                           logic last);
            logic [31:0] a;
            logic [31:0] b;
            block_out_t  r;
            a = a_in;
            b = b_in;
            if (cmd == CMD_ENCRYPT)
            begin
                a = a + subkeys[0];
                b = b + subkeys[1];
                for (int k = 1; k <= ROUNDS_N; k++)
                begin
                    a = rol(a ^ b, b[4:0]) + subkeys[2*k];
                    b = rol(b ^ a, a[4:0]) + subkeys[2*k+1];
                end
            end
            else
            begin
                for (int k = ROUNDS_N; k >= 1; k--)
                begin
                    b = ror(b - subkeys[2*k+1], a[4:0]) ^ a;
                    a = ror(a - subkeys[2*k], b[4:0]) ^ b;
                end
                b = b - subkeys[1];
                a = a - subkeys[0];
            end
            r.word_a = a;
            r.word_b = b;
            r.last   = last;
            return r;
        endfunction

        function void note_key(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            if (idx == REG_KEY_LOW)
                key_lo = data;
            else if (idx == REG_KEY_HIGH)
                key_hi = data;
            schedule_valid = 1'b0;
        endfunction

        function void note_block(logic cmd, logic [31:0] a, logic [31:0] b, logic last);
            if (!schedule_valid)
                expand_schedule();
            expected_blocks.push_back(rc5_transform(cmd, a, b, last));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_block(logic [31:0] a, logic [31:0] b, logic last);
            block_out_t e;
            if (expected_blocks.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat %h %h %b", a, b, last));
            end
            else
            begin
                e = expected_blocks.pop_front();
                if (a !== e.word_a)
                    report_mismatch($sformatf("word_a_out %h, want %h", a, e.word_a));
                if (b !== e.word_b)
                    report_mismatch($sformatf("word_b_out %h, want %h", b, e.word_b));
                if (last !== e.last)
                    report_mismatch($sformatf("last_out %b, want %b", last, e.last));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 command;
    logic [31:0]          word_a_in;
    logic [31:0]          word_b_in;
    logic                 last_in;
    logic                 done;
    logic [31:0]          word_a_out;
    logic [31:0]          word_b_out;
    logic                 last_out;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    cipher_scoreboard sb;
    int               stall_cycles;

    rc5_block_cipher #(
        .ROUNDS(ROUNDS_N)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .word_a_in  (word_a_in),
        .word_b_in  (word_b_in),
        .last_in    (last_in),
        .done       (done),
        .word_a_out (word_a_out),
        .word_b_out (word_b_out),
        .last_out   (last_out),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (done)
            sb.check_block(word_a_out, word_b_out, last_out);
        if ((start && !busy) || done || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL rc5_block_cipher");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return 32'h1 << $urandom_range(0, 31);
        return $urandom;
    endfunction

    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic send_block(logic cmd, logic [31:0] a, logic [31:0] b, logic lst, int gap);
        start     <= 1'b1;
        command   <= cmd;
        word_a_in <= a;
        word_b_in <= b;
        last_in   <= lst;
        do
            @(posedge clk);
        while (busy);
        sb.note_block(cmd, a, b, lst);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (sb.expected_blocks.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_key(bit wr_lo, bit wr_hi, logic [63:0] lo, logic [63:0] hi);
        if (wr_lo)
        begin
            cfg_write <= 1'b1;
            cfg_index <= REG_KEY_LOW;
            cfg_data  <= lo;
            @(posedge clk);
            sb.note_key(REG_KEY_LOW, lo);
        end
        if (wr_hi)
        begin
            cfg_write <= 1'b1;
            cfg_index <= REG_KEY_HIGH;
            cfg_data  <= hi;
            @(posedge clk);
            sb.note_key(REG_KEY_HIGH, hi);
        end
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int i;
        int mode;
        bit no_gap;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        command      = CMD_ENCRYPT;
        word_a_in    = '0;
        word_b_in    = '0;
        last_in      = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_KEY_LOW;
        cfg_data     = '0;
        sb           = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero key straight out of reset, no key write
        send_block(CMD_ENCRYPT, 32'h0, 32'h0, 1'b0, 0);
        send_block(CMD_ENCRYPT, '1, '1, 1'b1, 0);
        send_block(CMD_DECRYPT, 32'h0, 32'h0, 1'b0, 3);
        send_block(CMD_DECRYPT, '1, '1, 1'b1, 0);
        send_block(CMD_ENCRYPT, 32'h8000_0000, 32'h1, 1'b0, 17);
        send_block(CMD_DECRYPT, 32'h1, 32'h8000_0000, 1'b1, 0);
        send_block(CMD_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 0);
        send_block(CMD_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 0);
        wait_idle();

        load_key(1'b1, 1'b1, '1, '1);
        send_block(CMD_ENCRYPT, 32'h0, 32'h0, 1'b0, 0);
        send_block(CMD_DECRYPT, 32'h0, 32'h0, 1'b1, 0);
        send_block(CMD_ENCRYPT, '1, 32'h0, 1'b1, 2);
        send_block(CMD_DECRYPT, 32'h0, '1, 1'b0, 0);
        wait_idle();

        // rewrite one half only; the next beat must see a fresh schedule
        load_key(1'b1, 1'b0, 64'h0123_4567_89AB_CDEF, '0);
        send_block(CMD_ENCRYPT, 32'h0000_0020, 32'h0000_0040, 1'b0, 0);
        send_block(CMD_DECRYPT, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b1, 0);
        send_block(CMD_ENCRYPT, 32'hFFFF_FFE0, 32'h0000_001F, 1'b0, 0);
        wait_idle();
        load_key(1'b0, 1'b1, '0, 64'hFEDC_BA98_7654_3210);
        send_block(CMD_ENCRYPT, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 0);
        send_block(CMD_DECRYPT, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1);
        wait_idle();

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                load_key(1'b1, 1'b1, '0, '0);
            else if (phase == 1)
                load_key(1'b1, 1'b1, '1, '1);
            else
            begin
                mode = $urandom_range(0, 2);
                load_key(mode != 2, mode != 1, pick_key(), pick_key());
            end
            no_gap = ($urandom_range(0, 3) == 0);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                send_block($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT,
                           pick_word(), pick_word(), 1'($urandom_range(0, 1)),
                           no_gap ? 0 : pick_gap());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("PASS rc5_block_cipher");
        else
            $display("FAIL rc5_block_cipher");
        $finish;
    end

endmodule
